// ===== src/tsaq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_pkg
// Shared types and action codes of the time-sorted action queue.
// ----------------------------------------------------------------------------
package tsaq_pkg;

  // operation codes carried on the action field
  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActDelete = 2'd1;
  localparam logic [1:0] ActRead   = 2'd2;
  localparam logic [1:0] ActClear  = 2'd3;

  localparam int unsigned StampW = 32;
  localparam int unsigned RelayW = 8;
  localparam int unsigned CmdW   = 8;
  localparam int unsigned IndexW = 5;

  // one queue slot; a zero stamp marks an empty slot
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [RelayW-1:0] relay;
    logic [CmdW-1:0]   command;
  } entry_t;

endpackage

// ===== src/time_sorted_action_queue.sv =====
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one operation per cycle while results are taken; every slot compares against the new
// stamp at once and the whole row shifts in the same cycle.
// The result register frees up in the cycle its result is taken, so input
// is stalled only while an untaken result waits.
// Reset clears every slot at once; the queue is usable right after reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_sorted_action_queue
// Fixed-depth queue of relay actions kept sorted by ascending timestamp,
// with insert, delete at index, read at index and clear.
// ----------------------------------------------------------------------------
module time_sorted_action_queue import tsaq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [StampW-1:0] new_time_i,
  input  logic [RelayW-1:0] relay_number_i,
  input  logic [CmdW-1:0]   relay_command_i,
  input  logic [IndexW-1:0] entry_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [StampW-1:0] read_time_o,
  output logic [RelayW-1:0] read_relay_o,
  output logic [CmdW-1:0]   read_command_o
);

  logic exec;

  // handshake controller
  tsaq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .exec_o     (exec)
  );

  // slot row and result register
  tsaq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .exec_i         (exec),
    .action_i       (action_i),
    .new_time_i     (new_time_i),
    .relay_number_i (relay_number_i),
    .relay_command_i(relay_command_i),
    .entry_index_i  (entry_index_i),
    .ok_o           (ok_o),
    .read_time_o    (read_time_o),
    .read_relay_o   (read_relay_o),
    .read_command_o (read_command_o)
  );

endmodule

// ===== src/tsaq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_ctrl
// Handshake controller: decides when an operation executes and tracks
// whether the result register holds an untaken result.
// ----------------------------------------------------------------------------
module tsaq_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic exec_o
);

  localparam logic StEmpty = 1'b0;
  localparam logic StFull  = 1'b1;

  logic state_q, state_d;

  // a new transfer is taken whenever the result register frees up this cycle
  assign in_ready_o  = (state_q == StEmpty) || out_ready_i;
  assign exec_o      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StFull);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StEmpty: begin
        if (exec_o) state_d = StFull;
      end
      StFull: begin
        if (exec_o) state_d = StFull;
        else if (out_ready_i) state_d = StEmpty;
      end
      default: state_d = StEmpty;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StEmpty;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/tsaq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_datapath
// Row of queue slots that compare against the new stamp in parallel and
// shift down on insert or up on delete, plus the registered result.
// ----------------------------------------------------------------------------
module tsaq_datapath import tsaq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  logic [1:0]        action_i,
  input  logic [StampW-1:0] new_time_i,
  input  logic [RelayW-1:0] relay_number_i,
  input  logic [CmdW-1:0]   relay_command_i,
  input  logic [IndexW-1:0] entry_index_i,
  output logic              ok_o,
  output logic [StampW-1:0] read_time_o,
  output logic [RelayW-1:0] read_relay_o,
  output logic [CmdW-1:0]   read_command_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t ent_q [QUEUE_DEPTH];
  entry_t ent_d [QUEUE_DEPTH];
  entry_t prev_ent [QUEUE_DEPTH];
  entry_t next_ent [QUEUE_DEPTH];
  entry_t new_ent;
  entry_t rd_ent;

  logic [QUEUE_DEPTH-1:0] later;
  logic [QUEUE_DEPTH-1:0] shift_dn;
  logic                   in_range;
  logic [IdxW-1:0]        idx;

  logic              ok_q, ok_d;
  logic [StampW-1:0] rtime_q, rtime_d;
  logic [RelayW-1:0] rrelay_q, rrelay_d;
  logic [CmdW-1:0]   rcmd_q, rcmd_d;

  assign new_ent  = '{stamp: new_time_i, relay: relay_number_i, command: relay_command_i};
  assign in_range = ({1'b0, entry_index_i} < (IndexW + 1)'(QUEUE_DEPTH));
  assign idx      = entry_index_i[IdxW-1:0];

  // per-slot compare, neighbor taps and next value
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign later[i] = (ent_q[i].stamp == '0) || (ent_q[i].stamp > new_time_i);

    if (i == 0) begin : g_first
      assign shift_dn[i] = 1'b0;
      assign prev_ent[i] = '0;
    end else begin : g_rest
      assign shift_dn[i] = |later[i-1:0];
      assign prev_ent[i] = ent_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_ent[i] = '0;
    end else begin : g_mid
      assign next_ent[i] = ent_q[i+1];
    end

    always_comb begin
      ent_d[i] = ent_q[i];
      unique case (action_i)
        ActInsert: begin
          if (shift_dn[i]) ent_d[i] = prev_ent[i];
          else if (later[i]) ent_d[i] = new_ent;
        end
        ActDelete: begin
          if (in_range && (idx <= IdxW'(i))) ent_d[i] = next_ent[i];
        end
        ActRead:  ent_d[i] = ent_q[i];
        ActClear: ent_d[i] = '0;
        default:  ent_d[i] = ent_q[i];
      endcase
    end

    // slot register
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ent_q[i] <= '0;
      end else if (exec_i) begin
        ent_q[i] <= ent_d[i];
      end
    end
  end

  // read port and status
  assign rd_ent = ent_q[idx];

  always_comb begin
    ok_d     = 1'b0;
    rtime_d  = '0;
    rrelay_d = '0;
    rcmd_d   = '0;
    unique case (action_i)
      ActInsert: ok_d = |later;
      ActDelete: ok_d = in_range;
      ActRead: begin
        ok_d = in_range;
        if (in_range) begin
          rtime_d  = rd_ent.stamp;
          rrelay_d = rd_ent.relay;
          rcmd_d   = rd_ent.command;
        end
      end
      ActClear: ok_d = 1'b1;
      default:  ok_d = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      ok_q     <= ok_d;
      rtime_q  <= rtime_d;
      rrelay_q <= rrelay_d;
      rcmd_q   <= rcmd_d;
    end
  end

  assign ok_o           = ok_q;
  assign read_time_o    = rtime_q;
  assign read_relay_o   = rrelay_q;
  assign read_command_o = rcmd_q;

endmodule

// ===== src/tsaq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_checker
// Port-level checks of the time-sorted action queue, bound to the top level.
// ----------------------------------------------------------------------------
module tsaq_checker import tsaq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        action_i,
  input logic [IndexW-1:0] entry_index_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              ok_o,
  input logic [StampW-1:0] read_time_o,
  input logic [RelayW-1:0] read_relay_o,
  input logic [CmdW-1:0]   read_command_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // every input transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result after input transfer");

  // input is only stalled by a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  // clear always succeeds
  a_clear_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && action_i == ActClear) |=> (ok_o && read_time_o == '0))
    else $error("clear did not report success");

  // out-of-range read fails and returns an empty entry
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && action_i == ActRead &&
     {1'b0, entry_index_i} >= (IndexW + 1)'(QUEUE_DEPTH))
    |=> (!ok_o && read_time_o == '0 && read_relay_o == '0 && read_command_o == '0))
    else $error("out-of-range read not rejected");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(ok_o) &&
     $stable(read_time_o)))
    else $error("stalled result changed");

endmodule

bind time_sorted_action_queue tsaq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_tsaq_checker (.*);
